// ===== hw/rtl/dstq_pkg.sv =====
// Shared types and constants of the deadline sorted timer queue.
package dstq_pkg;

    localparam int QUEUE_DEPTH_DEF = 16;
    localparam int TAG_WIDTH_DEF   = 8;

    localparam int TIME_W    = 48;
    localparam int ELAPSED_W = 20;
    localparam int DELAY_W   = 24;
    localparam int TAG_W     = 8;
    localparam int WAIT_W    = 24;
    localparam int MS_W      = 10;

    // A delay of up to 2^24-1 ms is below 2^34 us, and time never passes
    // a deadline backwards, so a pending wait always fits in 34 bits.
    localparam int DIFF_W = 34;
    localparam int PROD_W = DELAY_W + MS_W;

    localparam logic [MS_W-1:0]   US_PER_MS = MS_W'(1000);
    localparam logic [TIME_W-1:0] TIME_MAX  = {TIME_W{1'b1}};

    localparam int MAX_RESULTS = 16;
    localparam int RES_IW      = $clog2(MAX_RESULTS);
    localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

    localparam logic FUNC_TICK     = 1'b0;
    localparam logic FUNC_SCHEDULE = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef struct packed {
        logic                 func;
        logic [ELAPSED_W-1:0] elapsed_us;
        logic [DELAY_W-1:0]   delay_ms;
        logic [TAG_W-1:0]     event_tag;
    } t_in;

    typedef struct packed {
        logic              event_valid;
        logic [TAG_W-1:0]  expired_tag;
        logic              last;
        logic              status;
        logic              queue_empty;
        logic [WAIT_W-1:0] next_wait_ms;
    } t_out;

endpackage

// ===== hw/rtl/dstq_div.sv =====
// Divider by the microseconds-per-millisecond constant, built as one reciprocal multiply.
module dstq_div
    import dstq_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DIFF_W-1:0] i_dividend,
    output logic              o_done,
    output logic [WAIT_W-1:0] o_quot
);

    // x / 1000 is (x / 8) / 125, and x / 8 fits in 31 bits. The reciprocal of 125,
    // scaled by 2^38 and rounded up, gives the exact floor over that whole range.
    localparam int                 PRE_SH    = 3;
    localparam int                 Y_W       = DIFF_W - PRE_SH;
    localparam int                 RECIP_W   = 32;
    localparam int                 RECIP_SH  = 38;
    localparam logic [RECIP_W-1:0] RECIP_125 = 32'd2199023256;
    localparam int                 P_W       = Y_W + RECIP_W;

    logic           r_done;
    logic [P_W-1:0] r_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_prod <= P_W'(i_dividend[DIFF_W-1:PRE_SH]) * P_W'(RECIP_125);
        end
    end

    assign o_done = r_done;
    assign o_quot = r_prod[RECIP_SH +: WAIT_W];

endmodule

// ===== hw/rtl/deadline_sorted_timer_queue_unit.sv =====
// Top level of the deadline sorted timer queue: sequencer, entry memory, result buffer.
// Schedule: the sorted insert walks the pending entries with later deadlines; a full queue skips it
// and answers with full status; a pending head wait is then divided into milliseconds.
// Tick: expired events are taken from the head, at most sixteen per tick; later result beats follow
// one per cycle while the output drains, and the next item is taken in the cycle after the last
// beat loads. Synchronous active-low reset clears state, time, count, head, indices and out valid.
module deadline_sorted_timer_queue_unit
    import dstq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
    parameter int TAG_WIDTH   = TAG_WIDTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    localparam int PW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int SW     = CW + 1;
    localparam int TW_MIN = (TAG_WIDTH < TAG_W) ? TAG_WIDTH : TAG_W;

    typedef struct packed {
        logic [TIME_W-1:0]    dl;
        logic [TAG_WIDTH-1:0] tag;
    } t_entry;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_DL   = 10'b0000000010,
        S_IRD  = 10'b0000000100,
        S_ICMP = 10'b0000001000,
        S_PRD  = 10'b0000010000,
        S_PCMP = 10'b0000100000,
        S_HRD  = 10'b0001000000,
        S_HCMP = 10'b0010000000,
        S_DIV  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    // Logical queue positions map onto a ring that starts at the head.
    function automatic logic [PW-1:0] phys(input logic [PW-1:0] head,
                                           input logic [CW-1:0] off);
        logic [SW-1:0] sum;
        sum = SW'(head) + SW'(off);
        if (sum >= SW'(QUEUE_DEPTH)) begin
            sum = sum - SW'(QUEUE_DEPTH);
        end
        return sum[PW-1:0];
    endfunction

    function automatic logic [TAG_WIDTH-1:0] tag_in(input logic [TAG_W-1:0] t);
        logic [TAG_WIDTH-1:0] v;
        v = '0;
        for (int b = 0; b < TW_MIN; b++) begin
            v[b] = t[b];
        end
        return v;
    endfunction

    function automatic logic [TAG_W-1:0] tag_out(input logic [TAG_WIDTH-1:0] t);
        logic [TAG_W-1:0] v;
        v = '0;
        for (int b = 0; b < TW_MIN; b++) begin
            v[b] = t[b];
        end
        return v;
    endfunction

    // Control state.
    t_state             r_state, n_state;
    logic [TIME_W-1:0]  r_time, n_time;
    logic [CW-1:0]      r_count, n_count;
    logic [PW-1:0]      r_head, n_head;
    logic [CW-1:0]      r_idx, n_idx;
    logic [RES_CW-1:0]  r_nres, n_nres;
    logic [RES_IW-1:0]  r_oidx, n_oidx;
    logic               r_ovalid, n_ovalid;

    // Payload of the item in flight.
    logic               r_sched, n_sched;
    logic               r_status, n_status;
    logic [TAG_WIDTH-1:0] r_tag, n_tag;
    logic [PROD_W-1:0]  r_prod, n_prod;
    logic [TIME_W-1:0]  r_dl, n_dl;
    logic [WAIT_W-1:0]  r_wait, n_wait;
    t_out               r_out, n_out;

    // Entry memory with one write port and one registered read port.
    t_entry             r_mem [QUEUE_DEPTH];
    t_entry             r_rd;
    logic [PW-1:0]      w_raddr;
    logic               w_we;
    logic [PW-1:0]      w_waddr;
    t_entry             w_wdata;

    // Tags of the events that expire on one tick wait here until the tick settles.
    // The read is registered at the index of the next result beat.
    logic [TAG_W-1:0]   r_rbuf [MAX_RESULTS];
    logic [TAG_W-1:0]   r_rb_rd;
    logic               w_rb_we;

    // Shared divider that turns the head wait from microseconds into milliseconds.
    logic               w_div_start;
    logic [DIFF_W-1:0]  w_div_arg;
    logic               w_div_done;
    logic [WAIT_W-1:0]  w_div_quot;

    logic [TIME_W:0]    w_tick_sum;
    logic [TIME_W:0]    w_dl_sum;
    logic [TIME_W-1:0]  w_diff;
    logic               w_in_acc;
    logic               w_load;
    logic               w_ev;
    logic               w_last;

    dstq_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_arg),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot)
    );

    assign w_in_acc   = i_in_valid && o_in_ready;
    assign w_tick_sum = {1'b0, r_time} + (TIME_W + 1)'(i_in_data.elapsed_us);
    assign w_dl_sum   = {1'b0, r_time} + (TIME_W + 1)'(r_prod);
    assign w_diff     = r_rd.dl - r_time;
    assign w_div_arg  = w_diff[DIFF_W-1:0];

    // In the output state, a result beat is loaded whenever the output register is free or drains.
    assign w_load = (r_state == S_OUT) && (!r_ovalid || i_out_ready);
    assign w_ev   = !r_sched && (r_nres != '0);
    assign w_last = !w_ev || ((RES_CW'(r_oidx) + RES_CW'(1)) == r_nres);

    always_comb begin
        n_state     = r_state;
        n_time      = r_time;
        n_count     = r_count;
        n_head      = r_head;
        n_idx       = r_idx;
        n_nres      = r_nres;
        n_oidx      = r_oidx;
        n_ovalid    = r_ovalid;
        n_sched     = r_sched;
        n_status    = r_status;
        n_tag       = r_tag;
        n_prod      = r_prod;
        n_dl        = r_dl;
        n_wait      = r_wait;
        n_out       = r_out;
        w_raddr     = r_head;
        w_we        = 1'b0;
        w_waddr     = phys(r_head, r_idx);
        w_wdata     = r_rd;
        w_rb_we     = 1'b0;
        w_div_start = 1'b0;

        if (r_ovalid && i_out_ready) begin
            n_ovalid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_sched  = (i_in_data.func == FUNC_SCHEDULE);
                    n_status = STATUS_OK;
                    n_tag    = tag_in(i_in_data.event_tag);
                    n_prod   = PROD_W'(i_in_data.delay_ms * US_PER_MS);
                    n_nres   = '0;
                    n_oidx   = '0;
                    if (i_in_data.func == FUNC_SCHEDULE) begin
                        if (r_count >= CW'(QUEUE_DEPTH)) begin
                            n_status = STATUS_FULL;
                            n_state  = S_HRD;
                        end else begin
                            n_state = S_DL;
                        end
                    end else begin
                        n_time  = w_tick_sum[TIME_W] ? TIME_MAX : w_tick_sum[TIME_W-1:0];
                        n_state = S_PRD;
                    end
                end
            end
            S_DL: begin
                n_dl    = w_dl_sum[TIME_W] ? TIME_MAX : w_dl_sum[TIME_W-1:0];
                n_idx   = r_count;
                n_state = S_IRD;
            end
            S_IRD: begin
                // Walk from the tail toward the head, with a read state and a compare state per entry.
                if (r_idx == '0) begin
                    w_we        = 1'b1;
                    w_wdata.dl  = r_dl;
                    w_wdata.tag = r_tag;
                    n_count     = r_count + CW'(1);
                    n_state     = S_HRD;
                end else begin
                    w_raddr = phys(r_head, r_idx - CW'(1));
                    n_state = S_ICMP;
                end
            end
            S_ICMP: begin
                w_we = 1'b1;
                if (r_rd.dl > r_dl) begin
                    n_idx   = r_idx - CW'(1);
                    n_state = S_IRD;
                end else begin
                    // Equal deadlines stay ahead of the new entry.
                    w_wdata.dl  = r_dl;
                    w_wdata.tag = r_tag;
                    n_count     = r_count + CW'(1);
                    n_state     = S_HRD;
                end
            end
            S_PRD: begin
                if (r_count == '0 || r_nres == RES_CW'(MAX_RESULTS)) begin
                    n_state = S_HRD;
                end else begin
                    n_state = S_PCMP;
                end
            end
            S_PCMP: begin
                if (r_rd.dl < r_time) begin
                    w_rb_we = 1'b1;
                    n_nres  = r_nres + RES_CW'(1);
                    n_count = r_count - CW'(1);
                    n_head  = (r_head == PW'(QUEUE_DEPTH - 1)) ? '0 : r_head + PW'(1);
                    n_state = S_PRD;
                end else begin
                    n_state = S_HRD;
                end
            end
            S_HRD: begin
                n_state = S_HCMP;
            end
            S_HCMP: begin
                if (r_count == '0 || r_rd.dl <= r_time) begin
                    n_wait  = '0;
                    n_state = S_OUT;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_wait  = w_div_quot;
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (w_load) begin
                    n_ovalid           = 1'b1;
                    n_out.event_valid  = w_ev;
                    n_out.expired_tag  = w_ev ? r_rb_rd : '0;
                    n_out.last         = w_last;
                    n_out.status       = r_status;
                    n_out.queue_empty  = (r_count == '0);
                    n_out.next_wait_ms = r_wait;
                    if (w_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_oidx = r_oidx + RES_IW'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_time   <= '0;
            r_count  <= '0;
            r_head   <= '0;
            r_idx    <= '0;
            r_nres   <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_time   <= n_time;
            r_count  <= n_count;
            r_head   <= n_head;
            r_idx    <= n_idx;
            r_nres   <= n_nres;
            r_oidx   <= n_oidx;
            r_ovalid <= n_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sched  <= n_sched;
        r_status <= n_status;
        r_tag    <= n_tag;
        r_prod   <= n_prod;
        r_dl     <= n_dl;
        r_wait   <= n_wait;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        r_rd <= r_mem[w_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (w_rb_we) begin
            r_rbuf[r_nres[RES_IW-1:0]] <= tag_out(r_rd.tag);
        end
        r_rb_rd <= r_rbuf[n_oidx];
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;

endmodule
